// ===== sv/error_diffusion_dither_rgb332_core_assert.svh =====
// assertion macros shared by the ditherer checker
// depends on signals named clk and arst_n in the using scope
`ifndef ERROR_DIFFUSION_DITHER_RGB332_CORE_ASSERT_SVH
`define ERROR_DIFFUSION_DITHER_RGB332_CORE_ASSERT_SVH

// cause in one cycle, consequence in the next, quiet during reset
`define EDD_ASSERT_NEXT(label, cause, conseq) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cause) |=> (conseq)) \
		else $error("ediff332 check failed: next-cycle rule");

// same-cycle implication, also checked while reset is held
`define EDD_ASSERT_SAME(label, cause, conseq) \
	label: assert property (@(posedge clk) (cause) |-> (conseq)) \
		else $error("ediff332 check failed: same-cycle rule");

// cause in one cycle, consequence in the next, also checked through reset
`define EDD_ASSERT_NEXT_RST(label, cause, conseq) \
	label: assert property (@(posedge clk) (cause) |=> (conseq)) \
		else $error("ediff332 check failed: next-cycle rule through reset");

`endif

// ===== sv/ediff332_pkg.sv =====
// shared types and constants for the rgb332 error diffusion ditherer
// no dependencies
package ediff332_pkg;

	localparam int NCH = 3;
	localparam int CH_B = 0;
	localparam int CH_G = 1;
	localparam int CH_R = 2;

	localparam int WIDTH_W = 12;
	localparam int HEIGHT_W = 13;
	localparam int ROW_W = 12;
	localparam int CFG_DATA_W = 13;

	localparam logic [WIDTH_W-1:0] WIDTH_RESET = 12'd640;
	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;

	// dropped low bits per channel: 6 for blue, 5 for green and red
	localparam logic [NCH-1:0][5:0] ERR_MASK = {6'h1F, 6'h1F, 6'h3F};

	typedef enum logic [0:0] {
		CFG_IMAGE_WIDTH  = 1'b0,
		CFG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	// one line store entry: pending next-row sum per channel
	typedef logic [NCH-1:0][5:0] sums_t;

	// per-channel running state between neighboring pixels
	typedef struct packed {
		logic [5:0] carried;
		logic [5:0] win0;
		logic [1:0] win1;
	} chan_state_t;

	typedef struct packed {
		chan_state_t nxt;
		logic [5:0] row_wr;
	} chan_next_t;

endpackage

// ===== sv/error_diffusion_dither_rgb332_core.sv =====
// rgb332 ditherer: an accepted pixel passes the stage 1 register, then the result
// register; one pixel per cycle while out_stall is low; the line store sees at most
// one read and one write a cycle; after reset a sweep zeroes all MAX_WIDTH entries
// while in_stall stays high; configuration writes are taken during the sweep
// all counters, error state and handshake flags reset to zero, registers to 640 x 480
module error_diffusion_dither_rgb332_core
	import ediff332_pkg::*;
#(
	parameter int MAX_WIDTH = 2048
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [0:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [7:0]            blue_in,
	input  logic [7:0]            green_in,
	input  logic [7:0]            red_in,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [7:0]            pixel_out,
	output logic                  row_end,
	output logic                  frame_end
);

	localparam int XW = $clog2(MAX_WIDTH);
	localparam int CW = ((XW > WIDTH_W) ? XW : WIDTH_W) + 1;
	localparam logic [XW-1:0] X_LAST = XW'(MAX_WIDTH - 1);

	logic [WIDTH_W-1:0] image_width_q;
	logic [HEIGHT_W-1:0] image_height_q;

	logic clearing_q;
	logic [XW-1:0] clr_idx_q;

	logic [XW-1:0] column_count_q;
	logic [ROW_W-1:0] row_count_q;

	logic in_accept;
	logic last_col_in;
	logic last_row_in;

	logic valid_s1;
	logic [NCH-1:0][7:0] pix_s1;
	logic [XW-1:0] x_s1;
	logic last_col_s1;
	logic last_row_s1;
	logic fwd_hit_s1;
	sums_t fwd_data_s1;

	chan_state_t [NCH-1:0] state_q;

	logic tail_valid_q;
	logic [XW-1:0] tail_addr_q;
	sums_t tail_data_q;

	logic out_valid_s2;
	logic [7:0] pixel_s2;
	logic row_end_s2;
	logic frame_end_s2;

	logic s1_adv;
	logic s1_wr;
	logic tail_wr;
	logic diffuse;
	logic [XW-1:0] s1_waddr;
	sums_t s1_wdata;
	sums_t ram_rdata;
	sums_t row_sums;
	logic [NCH-1:0][7:0] val;
	chan_next_t [NCH-1:0] chan_nxt;

	logic ram_we;
	logic [XW-1:0] ram_waddr;
	sums_t ram_wdata;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q <= WIDTH_RESET;
			image_height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_IMAGE_WIDTH:  image_width_q <= cfg_data[WIDTH_W-1:0];
				CFG_IMAGE_HEIGHT: image_height_q <= cfg_data[HEIGHT_W-1:0];
				default:          image_width_q <= image_width_q;
			endcase
		end
	end

	// line store clear after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_idx_q <= '0;
		end else if (clearing_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == X_LAST) begin
				clearing_q <= 1'b0;
			end
		end
	end

	assign s1_adv = valid_s1 && (!out_valid_s2 || !out_stall);
	assign in_stall = clearing_q || (valid_s1 && !s1_adv);
	assign in_accept = in_valid && !in_stall;

	// frame position; narrow widths clamp to two, tall heights to 4096 rows
	always_comb begin
		last_col_in = (column_count_q != '0) &&
			((CW'(column_count_q) + CW'(1) >= CW'(image_width_q)) ||
			 (column_count_q == X_LAST));
		last_row_in = ({1'b0, row_count_q} + 13'd1 >= image_height_q) ||
			(row_count_q == '1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q <= '0;
			row_count_q <= '0;
		end else if (in_accept) begin
			if (last_col_in) begin
				column_count_q <= '0;
				row_count_q <= last_row_in ? '0 : row_count_q + 1'b1;
			end else begin
				column_count_q <= column_count_q + 1'b1;
			end
		end
	end

	// stage 1 capture, with bypass of line store writes landing on the same entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			pix_s1[CH_B] <= blue_in;
			pix_s1[CH_G] <= green_in;
			pix_s1[CH_R] <= red_in;
			x_s1 <= column_count_q;
			last_col_s1 <= last_col_in;
			last_row_s1 <= last_row_in;
			if (s1_wr && s1_waddr == column_count_q) begin
				fwd_hit_s1 <= 1'b1;
				fwd_data_s1 <= s1_wdata;
			end else if (tail_valid_q && tail_addr_q == column_count_q) begin
				fwd_hit_s1 <= 1'b1;
				fwd_data_s1 <= tail_data_q;
			end else begin
				fwd_hit_s1 <= 1'b0;
				fwd_data_s1 <= tail_data_q;
			end
		end
	end

	assign row_sums = fwd_hit_s1 ? fwd_data_s1 : ram_rdata;
	assign diffuse = (x_s1 != '0) && !last_col_s1 && !last_row_s1;

	for (genvar c = 0; c < NCH; c++) begin : g_chan
		ediff332_chan u_chan (
			.pix      (pix_s1[c]),
			.row_sum  (row_sums[c]),
			.err_mask (ERR_MASK[c]),
			.diffuse  (diffuse),
			.cur      (state_q[c]),
			.val      (val[c]),
			.next     (chan_nxt[c])
		);
		assign s1_wdata[c] = chan_nxt[c].row_wr;
	end

	assign s1_waddr = x_s1 - 1'b1;
	assign s1_wr = s1_adv && (x_s1 != '0);
	assign tail_wr = tail_valid_q && !s1_wr;

	// running error state between neighbors
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (s1_adv) begin
			for (int c = 0; c < NCH; c++) begin
				state_q[c] <= last_col_s1 ? '0 : chan_nxt[c].nxt;
			end
		end
	end

	// the last column leaves a second line store write, done in the next free cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tail_valid_q <= 1'b0;
		end else if (s1_adv && last_col_s1) begin
			tail_valid_q <= 1'b1;
		end else if (tail_wr) begin
			tail_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && last_col_s1) begin
			tail_addr_q <= x_s1;
			for (int c = 0; c < NCH; c++) begin
				tail_data_q[c] <= chan_nxt[c].nxt.win0;
			end
		end
	end

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = clr_idx_q;
		ram_wdata = '0;
		if (clearing_q) begin
			ram_we = 1'b1;
		end else if (s1_wr) begin
			ram_we = 1'b1;
			ram_waddr = s1_waddr;
			ram_wdata = s1_wdata;
		end else if (tail_wr) begin
			ram_we = 1'b1;
			ram_waddr = tail_addr_q;
			ram_wdata = tail_data_q;
		end
	end

	ediff332_ram #(
		.WIDTH ($bits(sums_t)),
		.DEPTH (MAX_WIDTH)
	) u_line (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (in_accept),
		.raddr (column_count_q),
		.rdata (ram_rdata)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (s1_adv) begin
			out_valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			pixel_s2 <= {val[CH_R][7:5], val[CH_G][7:5], val[CH_B][7:6]};
			row_end_s2 <= last_col_s1;
			frame_end_s2 <= last_col_s1 && last_row_s1;
		end
	end

	assign out_valid = out_valid_s2;
	assign pixel_out = pixel_s2;
	assign row_end = row_end_s2;
	assign frame_end = frame_end_s2;

endmodule

// ===== sv/ediff332_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module ediff332_ram #(
	parameter int WIDTH = 18,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/ediff332_chan.sv =====
// one color channel: saturating sum, quantization error and error shares
// depends on ediff332_pkg
module ediff332_chan
	import ediff332_pkg::*;
(
	input  logic [7:0]  pix,
	input  logic [5:0]  row_sum,
	input  logic [5:0]  err_mask,
	input  logic        diffuse,
	input  chan_state_t cur,
	output logic [7:0]  val,
	output chan_next_t  next
);

	logic [8:0] carried7;
	logic [8:0] total;
	logic [5:0] err;
	logic [7:0] err3;
	logic [8:0] err5;

	always_comb begin
		// 7/16 of the left error
		carried7 = {cur.carried, 3'b000} - {3'b000, cur.carried};
		total = {1'b0, pix} + {3'b000, row_sum} + {4'b0000, carried7[8:4]};
		val = total[8] ? 8'hFF : total[7:0];
		err = diffuse ? (val[5:0] & err_mask) : 6'd0;
		err3 = {1'b0, err, 1'b0} + {2'b00, err};
		err5 = {1'b0, err, 2'b00} + {3'b000, err};
		next.row_wr = cur.win0 + {2'b00, err3[7:4]};
		next.nxt.win0 = {4'b0000, cur.win1} + {1'b0, err5[8:4]};
		next.nxt.win1 = err[5:4];
		next.nxt.carried = err;
	end

endmodule

// ===== sv/ediff332_checker.sv =====
// port-level checks for the rgb332 ditherer, bound to the top level
// depends on ediff332_pkg and error_diffusion_dither_rgb332_core_assert.svh
`include "error_diffusion_dither_rgb332_core_assert.svh"

module ediff332_checker
	import ediff332_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  cfg_we,
	input logic [0:0]            cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data,
	input logic                  in_valid,
	input logic                  in_stall,
	input logic [7:0]            blue_in,
	input logic [7:0]            green_in,
	input logic [7:0]            red_in,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic [7:0]            pixel_out,
	input logic                  row_end,
	input logic                  frame_end
);

	// a stalled request keeps its valid and its payload
	`EDD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
	`EDD_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable({pixel_out, row_end, frame_end}))
	// frame end is always the end of a row
	`EDD_ASSERT_SAME(a_frame_in_row, out_valid && frame_end, row_end)
	// once reset has been seen: no request out and the line store clear blocks input
	`EDD_ASSERT_NEXT_RST(a_reset_quiet, !arst_n, in_stall && !out_valid)

endmodule

bind error_diffusion_dither_rgb332_core ediff332_checker u_checker (.*);

// ===== dv/error_diffusion_dither_rgb332_checker.sv =====
// checker for the rgb332 ditherer: watches the pixel and result channels and the
// register port, predicts every result and compares field by field
// depends on ediff332_pkg
module error_diffusion_dither_rgb332_checker
	import ediff332_pkg::*;
#(
	parameter int MAX_WIDTH = 2048
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [0:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  logic [7:0]            blue_in,
	input  logic [7:0]            green_in,
	input  logic [7:0]            red_in,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  logic [7:0]            pixel_out,
	input  logic                  row_end,
	input  logic                  frame_end,
	output int                    mismatches,
	output int                    outstanding
);

	localparam int HEIGHT_CAP = 4096;

	typedef struct packed {
		logic [7:0] pixel;
		logic       row_end;
		logic       frame_end;
	} rgb332_result_t;

	// pending next-row sums per column, plus the two-column window and left error
	logic [7:0] line_sums [MAX_WIDTH][NCH];
	logic [7:0] left_win [NCH];
	logic [7:0] here_win [NCH];
	logic [7:0] left_err [NCH];
	logic [WIDTH_W-1:0] width_reg;
	logic [HEIGHT_W-1:0] height_reg;
	int unsigned col;
	int unsigned row;
	rgb332_result_t expected_pixels [$];

	function automatic rgb332_result_t dither_pixel(input logic [7:0] b, g, r);
		logic [7:0] pix [NCH];
		logic [7:0] level [NCH];
		logic [7:0] err [NCH];
		int unsigned w, h, x, sum;
		logic last_col, last_row, diffuse;
		rgb332_result_t res;
		pix[CH_B] = b;
		pix[CH_G] = g;
		pix[CH_R] = r;
		w = width_reg;
		if (w < 2) w = 2;
		if (w > MAX_WIDTH) w = MAX_WIDTH;
		h = height_reg;
		if (h < 1) h = 1;
		if (h > HEIGHT_CAP) h = HEIGHT_CAP;
		x = col;
		if (x >= MAX_WIDTH) x = MAX_WIDTH - 1;
		// counters left past the end by a register write count as last column / row
		last_col = x >= w - 1;
		last_row = row >= h - 1;
		diffuse = x != 0 && !last_col && !last_row;
		for (int c = 0; c < NCH; c++) begin
			sum = pix[c] + line_sums[x][c] + ((7 * left_err[c]) >> 4);
			if (sum > 255) sum = 255;
			level[c] = 8'(sum);
			err[c] = diffuse ? (level[c] & {2'b00, ERR_MASK[c]}) : 8'h00;
		end
		res.pixel = {level[CH_R][7:5], level[CH_G][7:5], level[CH_B][7:6]};
		res.row_end = last_col;
		res.frame_end = last_col && last_row;
		for (int c = 0; c < NCH; c++) begin
			if (x > 0) line_sums[x-1][c] = 8'(left_win[c] + ((3 * err[c]) >> 4));
			left_win[c] = 8'(here_win[c] + ((5 * err[c]) >> 4));
			here_win[c] = 8'(err[c] >> 4);
			left_err[c] = err[c];
		end
		if (last_col) begin
			for (int c = 0; c < NCH; c++) begin
				line_sums[x][c] = left_win[c];
				left_win[c] = 8'h00;
				here_win[c] = 8'h00;
				left_err[c] = 8'h00;
			end
			col = 0;
			row = last_row ? 0 : row + 1;
		end else begin
			col = x + 1;
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rgb332_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < MAX_WIDTH; i++)
				for (int c = 0; c < NCH; c++)
					line_sums[i][c] = 8'h00;
			for (int c = 0; c < NCH; c++) begin
				left_win[c] = 8'h00;
				here_win[c] = 8'h00;
				left_err[c] = 8'h00;
			end
			width_reg = WIDTH_RESET;
			height_reg = HEIGHT_RESET;
			col = 0;
			row = 0;
			expected_pixels.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_IMAGE_WIDTH: width_reg = cfg_data[WIDTH_W-1:0];
					CFG_IMAGE_HEIGHT: height_reg = cfg_data[HEIGHT_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				expected_pixels.push_back(dither_pixel(blue_in, green_in, red_in));
			if (out_valid && !out_stall) begin
				if (expected_pixels.size() == 0) begin
					mismatches++;
					$display("%0t: result with no request pending: pixel %h row_end %b frame_end %b",
						$time, pixel_out, row_end, frame_end);
				end else begin
					want = expected_pixels.pop_front();
					if (pixel_out !== want.pixel) begin
						mismatches++;
						$display("%0t: pixel_out expected %h actual %h", $time, want.pixel, pixel_out);
					end
					if (row_end !== want.row_end) begin
						mismatches++;
						$display("%0t: row_end expected %b actual %b", $time, want.row_end, row_end);
					end
					if (frame_end !== want.frame_end) begin
						mismatches++;
						$display("%0t: frame_end expected %b actual %b", $time, want.frame_end,
							frame_end);
					end
				end
			end
			outstanding = expected_pixels.size();
		end
	end

endmodule

// ===== dv/tb_error_diffusion_dither_rgb332_core.sv =====
// testbench top for the rgb332 ditherer: clock, reset, pixel requests, register
// writes and random stalls; the checker module does all prediction and comparison
// depends on ediff332_pkg, error_diffusion_dither_rgb332_core and the checker
module tb_error_diffusion_dither_rgb332_core;
	import ediff332_pkg::*;

	localparam int MAX_WIDTH = 2048;
	localparam int CYCLE_LIMIT = 600000;
	localparam int LONG_HOLD = 200;
	localparam int RANDOM_PIXELS = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [0:0] cfg_index = CFG_IMAGE_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] blue_in = 8'h00;
	logic [7:0] green_in = 8'h00;
	logic [7:0] red_in = 8'h00;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [7:0] pixel_out;
	logic row_end;
	logic frame_end;

	int mismatches;
	int outstanding;
	int cycles = 0;
	int hold_cycles;
	bit send_idle = 1'b0;
	bit recv_idle = 1'b0;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;

	error_diffusion_dither_rgb332_core #(.MAX_WIDTH(MAX_WIDTH)) uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.blue_in(blue_in), .green_in(green_in), .red_in(red_in),
		.out_valid(out_valid), .out_stall(out_stall),
		.pixel_out(pixel_out), .row_end(row_end), .frame_end(frame_end)
	);

	error_diffusion_dither_rgb332_checker #(.MAX_WIDTH(MAX_WIDTH)) u_check (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.blue_in(blue_in), .green_in(green_in), .red_in(red_in),
		.out_valid(out_valid), .out_stall(out_stall),
		.pixel_out(pixel_out), .row_end(row_end), .frame_end(frame_end),
		.mismatches(mismatches), .outstanding(outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("TEST FAILED");
		$finish;
	end

	// result side: random stall bursts, or one long hold when asked
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				out_stall <= 1'b1;
				for (hold_cycles = 0; hold_cycles < LONG_HOLD; hold_cycles++)
					@(posedge clk);
				out_stall <= 1'b0;
				hold_done = 1'b1;
			end else if (recv_idle && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 10)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	function automatic logic [7:0] channel_byte();
		case ($urandom_range(0, 4))
			0: return 8'h00;
			1: return 8'hFF;
			2: return {2'($urandom), 6'h3F};
			default: return 8'($urandom);
		endcase
	endfunction

	// one request, held until accepted; valid stays high afterwards
	task automatic send_pixel(input logic [7:0] b, g, r);
		if (send_idle && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_valid <= 1'b1;
		blue_in <= b;
		green_in <= g;
		red_in <= r;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic send_random_pixels(input int unsigned n);
		repeat (n) send_pixel(channel_byte(), channel_byte(), channel_byte());
	endtask

	// outstanding is updated at the rising edge, so it is read at the falling one
	task automatic pause_until_drained();
		in_valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input int unsigned value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(value);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_frame(input int unsigned w, h);
		pause_until_drained();
		write_reg(CFG_IMAGE_WIDTH, w);
		write_reg(CFG_IMAGE_HEIGHT, h);
	endtask

	initial begin
		int unsigned w, h, n;
		int phase;
		int random_sent;
		phase = 0;
		random_sent = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// reset geometry: black, saturating white, all dropped bits set, top bits only
		send_pixel(8'h00, 8'h00, 8'h00);
		send_pixel(8'hFF, 8'hFF, 8'hFF);
		send_pixel(8'hFF, 8'hFF, 8'hFF);
		send_pixel(8'h3F, 8'h1F, 8'h1F);
		send_pixel(8'hC0, 8'hE0, 8'hE0);
		// narrow the row while the column is already past its new end
		set_frame(3, 2);
		send_random_pixels(4);
		// zero width and height clamp to 2 x 1
		set_frame(0, 0);
		send_random_pixels(4);
		// shrink height below the current row mid-frame
		set_frame(4, 5);
		send_random_pixels(10);
		set_frame(1, 2);
		send_random_pixels(2);

		// widest rows: width above the store depth clamps to it
		set_frame(4095, 2);
		send_idle = 1'b1;
		recv_idle <= 1'b1;
		send_random_pixels(40);

		while (random_sent < RANDOM_PIXELS) begin
			case ($urandom_range(0, 9))
				0: w = $urandom_range(0, 1);
				1: w = $urandom_range(2040, 4095);
				default: w = $urandom_range(2, 8);
			endcase
			case ($urandom_range(0, 9))
				0: h = 0;
				1: h = $urandom_range(4096, 8191);
				default: h = $urandom_range(1, 5);
			endcase
			set_frame(w, h);
			send_idle = $urandom_range(0, 3) != 0;
			recv_idle <= $urandom_range(0, 3) != 0;
			if (phase == 3) begin
				// back up the result side so the block fills and stalls requests
				hold_req <= 1'b1;
				send_idle = 1'b0;
			end
			if (w >= 2 && w <= 8 && h >= 1 && h <= 5 && $urandom_range(0, 1) == 1)
				n = w * h * $urandom_range(1, 3);
			else
				n = $urandom_range(5, 40);
			send_random_pixels(n);
			random_sent += n;
			phase++;
		end

		// closing stretch at full rate
		set_frame(5, 3);
		send_idle = 1'b0;
		recv_idle <= 1'b0;
		send_random_pixels(45);
		pause_until_drained();

		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+sv
sv/ediff332_pkg.sv
sv/ediff332_ram.sv
sv/ediff332_chan.sv
sv/error_diffusion_dither_rgb332_core.sv
sv/ediff332_checker.sv
dv/error_diffusion_dither_rgb332_checker.sv
dv/tb_error_diffusion_dither_rgb332_core.sv
